@@ hdl/quantized_matmul_u2_output_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the 2-bit output matrix-multiply block
// Concurrent checks on clk_i with reset rst_ni; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef QUANTIZED_MATMUL_U2_OUTPUT_TOP_DEFINES_SVH
`define QUANTIZED_MATMUL_U2_OUTPUT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define QMU2_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define QMU2_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QMU2_ASSERT_IMP(lbl, ante, cons, msg)
`define QMU2_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/qmu2_pkg.sv @@
// ---------------------------------------------------------------------------
// qmu2_pkg
// Shared constants, codes and types of the 2-bit output matrix-multiply block.
// ---------------------------------------------------------------------------
`default_nettype none

package qmu2_pkg;

  // Channel table and group geometry.
  localparam int unsigned MaxChannels = 256;
  localparam int unsigned GroupSize   = 4;
  localparam int unsigned NumCols     = 2;
  localparam int unsigned NumLanes    = NumCols * GroupSize;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned GrpW        = $clog2(GroupSize);
  localparam int unsigned BankDepth   = MaxChannels / GroupSize;
  localparam int unsigned BankAddrW   = $clog2(BankDepth);

  // Field widths.
  localparam int unsigned ActW     = 8;
  localparam int unsigned WgtW     = 8;
  localparam int unsigned BiasW    = 8;
  localparam int unsigned ScaleW   = 32;
  localparam int unsigned AccW     = 32;
  localparam int unsigned MultW    = 16;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned ResW     = 2;
  localparam int unsigned OutW     = GroupSize * ResW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MacW     = ActW + WgtW + 1;
  localparam int unsigned ProdW    = ScaleW + 1 + AccW;
  localparam int unsigned SumW     = ProdW + 1;

  localparam logic [ResW-1:0] ResMax = '1;

  // Register reset values.
  localparam logic [MultW-1:0]  MultReset  = MultW'(1);
  localparam logic [ShiftW-1:0] ShiftReset = '0;

  typedef enum logic {
    OpLoad = 1'b0,
    OpMac  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMult  = 2'd0,
    CfgShift = 2'd1,
    CfgRelu  = 2'd2,
    CfgBn    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StAcc,
    StMul,
    StRes
  } state_e;

  typedef struct packed {
    logic [MultW-1:0]  mult;
    logic [ShiftW-1:0] shift;
    logic              relu;
    logic              bn;
  } cfg_t;

  typedef struct packed {
    logic acc_en;
    logic start;
    logic mul_en;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/qmu2_ram.sv @@
// ---------------------------------------------------------------------------
// qmu2_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module qmu2_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port; read data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/qmu2_lane.sv @@
// ---------------------------------------------------------------------------
// qmu2_lane
// One (column, channel) lane: accumulator, scale multiply and 2-bit requantize.
// ---------------------------------------------------------------------------
`default_nettype none

module qmu2_lane import qmu2_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctrl_t               ctrl_i,
  input  cfg_t                     cfg_i,
  input  logic        [ActW-1:0]   act_i,
  input  logic signed [WgtW-1:0]   weight_i,
  input  logic signed [BiasW-1:0]  bias_i,
  input  logic signed [ScaleW-1:0] kappa_i,
  input  logic signed [ScaleW-1:0] lambda_i,
  output logic        [ResW-1:0]   res_o
);

  logic signed [MacW-1:0]   mac_prod;
  logic        [AccW-1:0]   acc_base;
  logic        [AccW-1:0]   acc_d, acc_q;
  logic signed [ScaleW:0]   scale;
  logic signed [ProdW-1:0]  prod_d, prod_q;
  logic signed [SumW-1:0]   offs;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   shifted;
  logic                     use_bn;

  assign use_bn = cfg_i.relu && cfg_i.bn;

  // Multiply-accumulate; the first element of a group starts from the bias.
  assign mac_prod = $signed({1'b0, act_i}) * weight_i;
  assign acc_base = ctrl_i.start ? {{(AccW - BiasW){bias_i[BiasW-1]}}, bias_i} : acc_q;
  assign acc_d    = acc_base + {{(AccW - MacW){mac_prod[MacW-1]}}, mac_prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  // Scale factor of the selected requantize mode.
  always_comb begin
    if (use_bn) begin
      scale = {kappa_i[ScaleW-1], kappa_i};
    end else if (cfg_i.relu) begin
      scale = {{(ScaleW + 1 - MultW){1'b0}}, cfg_i.mult};
    end else begin
      scale = {{ScaleW{1'b0}}, 1'b1};
    end
  end

  // Exact product, registered before the offset add.
  assign prod_d = scale * $signed(acc_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Offset, arithmetic shift and clip to the 2-bit range.
  assign offs    = use_bn ? {{(SumW - ScaleW){lambda_i[ScaleW-1]}}, lambda_i} : '0;
  assign sum     = $signed({prod_q[ProdW-1], prod_q}) + offs;
  assign shifted = sum >>> cfg_i.shift;

  always_comb begin
    if (shifted[SumW-1]) begin
      res_o = '0;
    end else if (|shifted[SumW-2:ResW]) begin
      res_o = ResMax;
    end else begin
      res_o = shifted[ResW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/qmu2_merge.sv @@
// ---------------------------------------------------------------------------
// qmu2_merge
// Packs the eight lane results into two bytes and holds them for the consumer.
// ---------------------------------------------------------------------------
`default_nettype none

module qmu2_merge import qmu2_pkg::*; (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic [NumLanes-1:0][ResW-1:0]      res_i,
  input  logic                               out_stall_i,
  output logic                               ready_o,
  output logic                               out_valid_o,
  output logic [OutW-1:0]                    out_a_o,
  output logic [OutW-1:0]                    out_b_o
);

  logic [NumCols-1:0][OutW-1:0] data_d, data_q;
  logic                         valid_d, valid_q;

  // Channel k of a column lands in bits 2k+1:2k of that column's byte.
  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      data_d[c] = res_i[c*GroupSize +: GroupSize];
    end
  end

  // The output register is free when empty or when its request leaves now.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_a_o     = data_q[0];
  assign out_b_o     = data_q[1];

endmodule

`default_nettype wire

@@ hdl/quantized_matmul_u2_output_top.sv @@
// Flow: a MAC request marked last goes through table read, accumulate, 33x32 scale
// multiply and offset/shift/clip, then enters the output register once it is free.
// Throughput: loads and non-last MAC requests are taken every cycle while in_stall_o
// is low; a last MAC request stalls the input until its result is loaded.
// Reset: control, configuration and accumulators are cleared to their reset values;
// the bias, kappa and lambda tables are not cleared and hold garbage until loaded.
`default_nettype none
`include "quantized_matmul_u2_output_top_defines.svh"

module quantized_matmul_u2_output_top import qmu2_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [ChanW-1:0]     channel_i,
  input  logic [BiasW-1:0]     bias_i,
  input  logic [ScaleW-1:0]    kappa_i,
  input  logic [ScaleW-1:0]    lambda_offset_i,
  input  logic [ActW-1:0]      act_a_i,
  input  logic [ActW-1:0]      act_b_i,
  input  logic [WgtW-1:0]      weight_0_i,
  input  logic [WgtW-1:0]      weight_1_i,
  input  logic [WgtW-1:0]      weight_2_i,
  input  logic [WgtW-1:0]      weight_3_i,
  input  logic                 last_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OutW-1:0]      out_a_o,
  output logic [OutW-1:0]      out_b_o
);

  cfg_t                          cfg_d, cfg_q;
  state_e                        state_d, state_q;
  logic                          in_acc, mac_acc, load_acc;
  logic                          last_q;
  logic                          group_start_d, group_start_q;
  logic [NumCols-1:0][ActW-1:0]  act_in, act_q;
  logic [GroupSize-1:0][WgtW-1:0] wgt_in, wgt_q;
  logic [BankAddrW-1:0]          bank_addr;
  logic [GroupSize-1:0][BiasW-1:0]  bias_rd;
  logic [GroupSize-1:0][ScaleW-1:0] kappa_rd;
  logic [GroupSize-1:0][ScaleW-1:0] lambda_rd;
  logic [NumLanes-1:0][ResW-1:0] lane_res;
  lane_ctrl_t                    lane_ctrl;
  logic                          merge_ready;
  logic                          merge_load;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMult:  cfg_d.mult  = cfg_data_i[MultW-1:0];
        CfgShift: cfg_d.shift = cfg_data_i[ShiftW-1:0];
        CfgRelu:  cfg_d.relu  = cfg_data_i[0];
        CfgBn:    cfg_d.bn    = cfg_data_i[0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mult: MultReset, shift: ShiftReset, relu: 1'b0, bn: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input handshake: open when idle or while a non-final MAC is accumulating.
  assign in_stall_o = !((state_q == StIdle) || ((state_q == StAcc) && !last_q));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mac_acc    = in_acc && (op_e'(operation_i) == OpMac);
  assign load_acc   = in_acc && (op_e'(operation_i) == OpLoad);

  // Channel tables, banked by the low channel bits so all channels of a group read together.
  assign bank_addr = channel_i[GrpW +: BankAddrW];

  for (genvar k = 0; k < GroupSize; k++) begin : g_bank
    logic bank_we;
    assign bank_we = load_acc && (channel_i[GrpW-1:0] == GrpW'(k));

    qmu2_ram #(.Width(BiasW), .Depth(BankDepth)) u_bias_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (bank_addr),
      .wdata_i (bias_i),
      .re_i    (mac_acc),
      .raddr_i (bank_addr),
      .rdata_o (bias_rd[k])
    );

    qmu2_ram #(.Width(ScaleW), .Depth(BankDepth)) u_kappa_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (bank_addr),
      .wdata_i (kappa_i),
      .re_i    (mac_acc),
      .raddr_i (bank_addr),
      .rdata_o (kappa_rd[k])
    );

    qmu2_ram #(.Width(ScaleW), .Depth(BankDepth)) u_lambda_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (bank_addr),
      .wdata_i (lambda_offset_i),
      .re_i    (mac_acc),
      .raddr_i (bank_addr),
      .rdata_o (lambda_rd[k])
    );
  end

  // Operand registers of the MAC request waiting for its table data.
  assign act_in = {act_b_i, act_a_i};
  assign wgt_in = {weight_3_i, weight_2_i, weight_1_i, weight_0_i};

  always_ff @(posedge clk_i) begin
    if (mac_acc) begin
      act_q <= act_in;
      wgt_q <= wgt_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (mac_acc) begin
      last_q <= last_i;
    end
  end

  // Sequencer: accumulate, then multiply and requantize after the final element.
  always_comb begin
    state_d       = state_q;
    group_start_d = group_start_q;
    merge_load    = 1'b0;
    case (state_q)
      StIdle: begin
        if (mac_acc) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        group_start_d = last_q;
        if (last_q) begin
          state_d = StMul;
        end else if (mac_acc) begin
          state_d = StAcc;
        end else begin
          state_d = StIdle;
        end
      end
      StMul: begin
        state_d = StRes;
      end
      StRes: begin
        if (merge_ready) begin
          merge_load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      group_start_q <= 1'b1;
    end else begin
      state_q       <= state_d;
      group_start_q <= group_start_d;
    end
  end

  assign lane_ctrl.acc_en = (state_q == StAcc);
  assign lane_ctrl.start  = group_start_q;
  assign lane_ctrl.mul_en = (state_q == StMul);

  // Eight lanes: column c, channel k of the group.
  for (genvar c = 0; c < NumCols; c++) begin : g_col
    for (genvar k = 0; k < GroupSize; k++) begin : g_chan
      qmu2_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (lane_ctrl),
        .cfg_i    (cfg_q),
        .act_i    (act_q[c]),
        .weight_i (wgt_q[k]),
        .bias_i   (bias_rd[k]),
        .kappa_i  (kappa_rd[k]),
        .lambda_i (lambda_rd[k]),
        .res_o    (lane_res[c*GroupSize + k])
      );
    end
  end

  // Merge stage and output register.
  qmu2_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (merge_load),
    .res_i       (lane_res),
    .out_stall_i (out_stall_i),
    .ready_o     (merge_ready),
    .out_valid_o (out_valid_o),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o)
  );

  // A final MAC request always enters accumulation with its last flag held.
  `QMU2_ASSERT_NXT(a_last_mac_enters_acc, mac_acc && last_i, (state_q == StAcc) && last_q, "final MAC request did not reach accumulation")
  // Table outputs must not move while the requantize stage uses them.
  `QMU2_ASSERT_IMP(a_tables_hold_in_res, state_q == StRes, $stable(lambda_rd) && $stable(kappa_rd), "table read data changed during requantize")
  // A new result only appears from the requantize stage.
  `QMU2_ASSERT_IMP(a_result_from_res, $rose(out_valid_o), $past(state_q) == StRes, "result valid rose outside requantize")

endmodule

`default_nettype wire
